// ----- rtl/ibeu_pkg.sv -----
`default_nettype none
package ibeu_pkg;

  typedef enum logic [4:0] {
    CMD_ADDI  = 5'd0,  CMD_ADDIS = 5'd1,  CMD_ADD   = 5'd2,  CMD_SUBF  = 5'd3,
    CMD_MULLI = 5'd4,  CMD_MULLW = 5'd5,  CMD_DIVW  = 5'd6,  CMD_ORI   = 5'd7,
    CMD_ORIS  = 5'd8,  CMD_XORI  = 5'd9,  CMD_XORIS = 5'd10, CMD_ANDI  = 5'd11,
    CMD_ANDIS = 5'd12, CMD_AND   = 5'd13, CMD_OR    = 5'd14, CMD_XOR   = 5'd15,
    CMD_CMPI  = 5'd16, CMD_CMP   = 5'd17, CMD_CMPLI = 5'd18, CMD_CMPL  = 5'd19,
    CMD_B     = 5'd20, CMD_BC    = 5'd21, CMD_BCLR  = 5'd22, CMD_BCCTR = 5'd23
  } cmd_t;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_SO    = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [31:0] CR_TOP_FIELD  = 32'hF0000000;
  localparam logic [31:0] CR_LOW_FIELDS = 32'h0FFFFFFF;
  localparam logic [4:0]  BO_NO_COND = 5'h10;
  localparam logic [4:0]  BO_COND_TRUE = 5'h08;
  localparam logic [4:0]  BO_NO_CTR = 5'h04;
  localparam logic [4:0]  BO_CTR_ZERO = 5'h02;

  typedef struct packed {
    logic [4:0]  command;
    logic [31:0] instr_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic [31:0] cond_value;
    logic        branch_taken;
    logic        divide_by_zero;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // latch item, read operands
    logic div_start;
    logic div_step;
    logic mul_fin;  // register multiply result
    logic commit;   // write back and form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_div;
    logic is_mul;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/integer_and_branch_execute_unit_core.sv -----
// Integer and branch execute unit.
// Input channel in_valid/in_ready carries one instruction transaction
// (command and instruction word); the output channel out_valid/out_ready
// returns one result per instruction: next pc, register write, CR, flags.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set the
// start address, the summary overflow bit and the count preset; take them
// only while no instruction is in flight.
// Most operations pass through the decode and done states; multiplies add a
// multiply state and divw a divide state (one quotient bit per cycle in the
// restoring divider). One instruction is in flight at a time; the next one is
// taken in the cycle its predecessor's result is accepted.
// Reset (rst, synchronous) clears CR, LR, PC, CTR and configuration; the
// general registers start as zero.
// When the receiver stalls the result holds and no further input is taken.
`default_nettype none
module integer_and_branch_execute_unit_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ibeu_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ibeu_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  ibeu_pkg::dp_cmd_t  cmd;
  ibeu_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ibeu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  ibeu_dpath u_dpath (
    .clk(clk), .rst(rst), .in_item(in_data), .cfg_we(cfg_valid),
    .cfg_idx(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
    .result(out_data)
  );
endmodule
`default_nettype wire

// ----- rtl/ibeu_ctrl.sv -----
`default_nettype none
module ibeu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ibeu_pkg::dp_cmd_t       cmd,
  input  wire ibeu_pkg::dp_stat_t stat
);
  typedef enum logic [2:0] {S_IDLE, S_DEC, S_DIV, S_MUL, S_DONE} state_t;
  state_t state;

  // accept while idle, or while the finished result leaves
  assign in_ready = (state == S_IDLE) || (state == S_DONE && out_ready);
  assign out_valid = (state == S_DONE);

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    cmd.div_start = (state == S_DEC) && stat.is_div;
    cmd.div_step = (state == S_DIV);
    cmd.mul_fin = (state == S_DEC) && stat.is_mul;
    cmd.commit = ((state == S_DEC) && !stat.is_div && !stat.is_mul) ||
                 ((state == S_DIV) && stat.div_last) || (state == S_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DEC;
        S_DEC: begin
          if (stat.is_div) state <= S_DIV;
          else if (stat.is_mul) state <= S_MUL;
          else state <= S_DONE;
        end
        S_DIV: if (stat.div_last) state <= S_DONE;
        S_MUL: state <= S_DONE;
        S_DONE: begin
          if (out_ready) state <= in_valid ? S_DEC : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/ibeu_dpath.sv -----
`default_nettype none
module ibeu_dpath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ibeu_pkg::in_item_t in_item,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [31:0]        cfg_data,
  input  wire ibeu_pkg::dp_cmd_t  cmd,
  output ibeu_pkg::dp_stat_t      stat,
  output ibeu_pkg::out_item_t     result
);
  logic [31:0] regs [32];
  logic [31:0] cr, ctr, lr, pc;
  logic        so;
  logic [4:0]  op;
  logic [31:0] w, a_val, b_val, s_val;
  logic [31:0] prod;
  // divider
  logic [31:0] quo, rem_r, dvs;
  logic [5:0]  cnt;
  logic        neg_q;

  logic [4:0] rd, ra;
  logic [31:0] simm, uimm, uimm_hi;
  assign rd = w[25:21];
  assign ra = w[20:16];
  assign simm = {{16{w[15]}}, w[15:0]};
  assign uimm = {16'd0, w[15:0]};
  assign uimm_hi = {w[15:0], 16'd0};

  assign stat.is_div = (op == ibeu_pkg::CMD_DIVW) && (b_val != 32'd0);
  assign stat.is_mul = (op == ibeu_pkg::CMD_MULLI) || (op == ibeu_pkg::CMD_MULLW);
  assign stat.div_last = (cnt == 6'd31);

  // one restoring divide step
  logic [32:0] trial;
  logic [31:0] rem_sh;
  assign rem_sh = {rem_r[30:0], quo[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, dvs};

  logic [31:0] q_fin;
  assign q_fin = {quo[30:0], !trial[32]};

  // execute
  logic [31:0] val, tgt, ctr_dec, here4, cr_new, li, bd, ca, cb;
  logic [4:0]  idx;
  logic        wr, setcr, taken, dz, cmp_un, do_cmp, ctr_ok, cr_ok, bit_sel, dec_ctr;
  logic [1:0]  kind;
  logic [2:0]  fld;
  logic [31:0] fmask, fbits;

  always_comb begin
    val = 32'd0; idx = rd; wr = 1'b0; setcr = 1'b0; taken = 1'b0; dz = 1'b0;
    tgt = 32'd0; do_cmp = 1'b0; cmp_un = 1'b0; ca = a_val; cb = b_val;
    dec_ctr = 1'b0;
    here4 = pc + 32'd4;
    ctr_dec = ctr - 32'd1;
    li = {{6{w[25]}}, w[25:2], 2'b00};
    bd = {{16{w[15]}}, w[15:2], 2'b00};
    bit_sel = cr[5'd31 - ra];
    cr_ok = rd[4] || (rd[3] ? bit_sel : !bit_sel);
    ctr_ok = rd[2] || (rd[1] ? (ctr_dec == 32'd0) : (ctr_dec != 32'd0));
    unique case (op)
      ibeu_pkg::CMD_ADDI:  begin val = (ra != 5'd0 ? a_val : 32'd0) + simm; wr = 1'b1; end
      ibeu_pkg::CMD_ADDIS: begin val = (ra != 5'd0 ? a_val : 32'd0) + uimm_hi; wr = 1'b1; end
      ibeu_pkg::CMD_ADD:   begin val = a_val + b_val; wr = 1'b1; setcr = w[0]; end
      ibeu_pkg::CMD_SUBF:  begin val = b_val - a_val; wr = 1'b1; setcr = w[0]; end
      ibeu_pkg::CMD_MULLI: begin val = prod; wr = 1'b1; end
      ibeu_pkg::CMD_MULLW: begin val = prod; wr = 1'b1; setcr = w[0]; end
      ibeu_pkg::CMD_DIVW: begin
        if (b_val == 32'd0) dz = 1'b1;
        else begin val = neg_q ? (32'd0 - q_fin) : q_fin; wr = 1'b1; setcr = w[0]; end
      end
      ibeu_pkg::CMD_ORI:   begin val = s_val | uimm; idx = ra; wr = 1'b1; end
      ibeu_pkg::CMD_ORIS:  begin val = s_val | uimm_hi; idx = ra; wr = 1'b1; end
      ibeu_pkg::CMD_XORI:  begin val = s_val ^ uimm; idx = ra; wr = 1'b1; end
      ibeu_pkg::CMD_XORIS: begin val = s_val ^ uimm_hi; idx = ra; wr = 1'b1; end
      ibeu_pkg::CMD_ANDI:  begin val = s_val & uimm; idx = ra; wr = 1'b1; setcr = 1'b1; end
      ibeu_pkg::CMD_ANDIS: begin val = s_val & uimm_hi; idx = ra; wr = 1'b1; setcr = 1'b1; end
      ibeu_pkg::CMD_AND:   begin val = s_val & b_val; idx = ra; wr = 1'b1; setcr = w[0]; end
      ibeu_pkg::CMD_OR:    begin val = s_val | b_val; idx = ra; wr = 1'b1; setcr = w[0]; end
      ibeu_pkg::CMD_XOR:   begin val = s_val ^ b_val; idx = ra; wr = 1'b1; setcr = w[0]; end
      ibeu_pkg::CMD_CMPI:  begin do_cmp = 1'b1; cb = simm; end
      ibeu_pkg::CMD_CMP:   do_cmp = 1'b1;
      ibeu_pkg::CMD_CMPLI: begin do_cmp = 1'b1; cmp_un = 1'b1; cb = uimm; end
      ibeu_pkg::CMD_CMPL:  begin do_cmp = 1'b1; cmp_un = 1'b1; end
      ibeu_pkg::CMD_B: begin taken = 1'b1; tgt = w[1] ? li : pc + li; end
      ibeu_pkg::CMD_BC: begin
        dec_ctr = !rd[2];
        taken = cr_ok && ctr_ok; tgt = w[1] ? bd : pc + bd;
      end
      ibeu_pkg::CMD_BCLR: begin dec_ctr = !rd[2]; taken = cr_ok && ctr_ok; tgt = lr; end
      ibeu_pkg::CMD_BCCTR: begin taken = cr_ok; tgt = ctr; end
      default: ;
    endcase
    if (!wr) idx = 5'd0;
    // compare kind for CR field update: 0 less, 1 greater, 2 equal
    if (!do_cmp) begin ca = val; cb = 32'd0; end
    if (cmp_un) kind = (ca < cb) ? 2'd0 : (ca > cb) ? 2'd1 : 2'd2;
    else kind = ($signed(ca) < $signed(cb)) ? 2'd0 :
                ($signed(ca) > $signed(cb)) ? 2'd1 : 2'd2;
    fld = do_cmp ? w[25:23] : 3'd0;
    fmask = ibeu_pkg::CR_TOP_FIELD >> {fld, 2'b00};
    fbits = ({(4'b1000 >> kind) | {3'b000, so}, 28'd0}) >> {fld, 2'b00};
    cr_new = (do_cmp || (wr && setcr)) ? ((cr & ~fmask) | fbits) : cr;
  end

  // multiplier operand, sign of immediate form handled by extension
  logic [31:0] mul_b;
  assign mul_b = (op == ibeu_pkg::CMD_MULLI) ? simm : b_val;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_item.command;
      w <= in_item.instr_word;
      a_val <= regs[in_item.instr_word[20:16]];
      b_val <= regs[in_item.instr_word[15:11]];
      s_val <= regs[in_item.instr_word[25:21]];
    end
    if (cmd.mul_fin) prod <= a_val * mul_b;
    if (cmd.div_start) begin
      quo <= a_val[31] ? (32'd0 - a_val) : a_val;
      dvs <= b_val[31] ? (32'd0 - b_val) : b_val;
      rem_r <= 32'd0;
      neg_q <= a_val[31] ^ b_val[31];
    end else if (cmd.div_step) begin
      rem_r <= trial[32] ? rem_sh : trial[31:0];
      quo <= q_fin;
    end
    if (cmd.commit) begin
      result.next_pc <= taken ? tgt : here4;
      result.dest_index <= idx;
      result.dest_value <= val;
      result.dest_written <= wr;
      result.cond_value <= cr_new;
      result.branch_taken <= taken;
      result.divide_by_zero <= dz;
    end
  end

  // general registers: clear on reset, write back on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else if (cmd.commit && wr) begin
      regs[idx] <= val;
    end
  end

  // divide step counter; multiply lands in the cycle after issue
  always_ff @(posedge clk) begin
    if (rst) cnt <= 6'd0;
    else if (cmd.div_start) cnt <= 6'd0;
    else if (cmd.div_step) cnt <= cnt + 6'd1;
  end

  // architectural state: reset clears it, configuration loads PC, SO and CTR, commit updates it
  always_ff @(posedge clk) begin
    if (rst) begin
      cr <= '0; lr <= '0; pc <= '0; ctr <= '0; so <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ibeu_pkg::CFG_START: pc <= cfg_data;
        ibeu_pkg::CFG_SO:    so <= cfg_data[0];
        ibeu_pkg::CFG_COUNT: ctr <= cfg_data;
        default: ;
      endcase
    end else if (cmd.commit) begin
      cr <= cr_new;
      pc <= taken ? tgt : here4;
      if (taken && w[0]) lr <= here4;
      if (dec_ctr) ctr <= ctr_dec;
    end
  end
endmodule
`default_nettype wire

// ----- tb/integer_and_branch_execute_unit_core_test.sv -----
`default_nettype none
module integer_and_branch_execute_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ibeu_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ibeu_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  integer_and_branch_execute_unit_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // architectural state of the predictor
  logic [31:0] gpr [32];
  logic [31:0] cr_q, ctr_q, lr_q, pc_q;
  logic        so_q;

  ibeu_pkg::in_item_t  instr_queue [$];
  ibeu_pkg::out_item_t result_queue [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_active = 1'b0;

  // cfg write request handed to the driver
  logic        cfg_req = 1'b0;
  logic [1:0]  cfg_req_index;
  logic [31:0] cfg_req_data;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // 0 less, 1 greater, 2 equal
  function automatic int cmp_kind(input logic [31:0] a, input logic [31:0] b,
                                  input bit sgn);
    if (sgn) begin
      if ($signed(a) < $signed(b)) return 0;
      if ($signed(a) > $signed(b)) return 1;
    end else begin
      if (a < b) return 0;
      if (a > b) return 1;
    end
    return 2;
  endfunction

  function automatic void set_cr_field(input logic [2:0] fld, input int kind);
    int unsigned sh;
    sh = fld * 4;
    cr_q &= ~(ibeu_pkg::CR_TOP_FIELD >> sh);
    cr_q |= (32'h80000000 >> kind) >> sh;
    if (so_q) cr_q |= 32'h10000000 >> sh;
  endfunction

  function automatic bit cr_ok(input logic [4:0] bo, input logic [4:0] bi);
    logic bitv;
    if ((bo & ibeu_pkg::BO_NO_COND) != 0) return 1'b1;
    bitv = cr_q[31 - bi];
    return ((bo & ibeu_pkg::BO_COND_TRUE) != 0) ? bitv : !bitv;
  endfunction

  function automatic bit ctr_ok(input logic [4:0] bo);
    if ((bo & ibeu_pkg::BO_NO_CTR) != 0) return 1'b1;
    ctr_q = ctr_q - 1;
    return ((bo & ibeu_pkg::BO_CTR_ZERO) != 0) ? (ctr_q == 0) : (ctr_q != 0);
  endfunction

  // execute one instruction against the predictor state
  function automatic ibeu_pkg::out_item_t execute(input ibeu_pkg::in_item_t it);
    ibeu_pkg::out_item_t r;
    logic [31:0] w, a, b, s, here, v, tgt, simm, uimm, li, bd, ma, mb, q;
    logic [4:0] rd, ra, rb, idx;
    bit wr, tk, dz, setcr, c;
    w = it.instr_word;
    rd = w[25:21]; ra = w[20:16]; rb = w[15:11];
    simm = sext16(w[15:0]); uimm = {16'h0, w[15:0]};
    a = gpr[ra]; b = gpr[rb]; s = gpr[rd];
    here = pc_q; pc_q = here + 4;
    v = 0; idx = 0; tgt = 0; wr = 0; tk = 0; dz = 0; setcr = 0;
    case (it.command)
      ibeu_pkg::CMD_ADDI:  begin v = (ra != 0 ? a : 0) + simm; idx = rd; wr = 1; end
      ibeu_pkg::CMD_ADDIS: begin v = (ra != 0 ? a : 0) + (uimm << 16); idx = rd; wr = 1; end
      ibeu_pkg::CMD_ADD:   begin v = a + b; idx = rd; wr = 1; setcr = w[0]; end
      ibeu_pkg::CMD_SUBF:  begin v = b - a; idx = rd; wr = 1; setcr = w[0]; end
      ibeu_pkg::CMD_MULLI: begin v = a * simm; idx = rd; wr = 1; end
      ibeu_pkg::CMD_MULLW: begin v = a * b; idx = rd; wr = 1; setcr = w[0]; end
      ibeu_pkg::CMD_DIVW: begin
        if (b == 0) dz = 1;
        else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          v = (a[31] ^ b[31]) ? -q : q;
          idx = rd; wr = 1; setcr = w[0];
        end
      end
      ibeu_pkg::CMD_ORI:   begin v = s | uimm; idx = ra; wr = 1; end
      ibeu_pkg::CMD_ORIS:  begin v = s | (uimm << 16); idx = ra; wr = 1; end
      ibeu_pkg::CMD_XORI:  begin v = s ^ uimm; idx = ra; wr = 1; end
      ibeu_pkg::CMD_XORIS: begin v = s ^ (uimm << 16); idx = ra; wr = 1; end
      ibeu_pkg::CMD_ANDI:  begin v = s & uimm; idx = ra; wr = 1; setcr = 1; end
      ibeu_pkg::CMD_ANDIS: begin v = s & (uimm << 16); idx = ra; wr = 1; setcr = 1; end
      ibeu_pkg::CMD_AND:   begin v = s & b; idx = ra; wr = 1; setcr = w[0]; end
      ibeu_pkg::CMD_OR:    begin v = s | b; idx = ra; wr = 1; setcr = w[0]; end
      ibeu_pkg::CMD_XOR:   begin v = s ^ b; idx = ra; wr = 1; setcr = w[0]; end
      ibeu_pkg::CMD_CMPI:  set_cr_field(w[25:23], cmp_kind(a, simm, 1));
      ibeu_pkg::CMD_CMP:   set_cr_field(w[25:23], cmp_kind(a, b, 1));
      ibeu_pkg::CMD_CMPLI: set_cr_field(w[25:23], cmp_kind(a, uimm, 0));
      ibeu_pkg::CMD_CMPL:  set_cr_field(w[25:23], cmp_kind(a, b, 0));
      ibeu_pkg::CMD_B: begin
        li = w & 32'h03FFFFFC;
        if (li[25]) li |= 32'hFC000000;
        tgt = w[1] ? li : here + li;
        tk = 1;
      end
      ibeu_pkg::CMD_BC: begin
        bd = sext16(w[15:0] & 16'hFFFC);
        c = ctr_ok(rd);
        if (cr_ok(rd, ra) && c) begin tgt = w[1] ? bd : here + bd; tk = 1; end
      end
      ibeu_pkg::CMD_BCLR: begin
        c = ctr_ok(rd);
        if (cr_ok(rd, ra) && c) begin tgt = lr_q; tk = 1; end
      end
      ibeu_pkg::CMD_BCCTR: if (cr_ok(rd, ra)) begin tgt = ctr_q; tk = 1; end
      default: ;
    endcase
    if (wr) begin
      gpr[idx] = v;
      if (setcr) begin
        cr_q &= ibeu_pkg::CR_LOW_FIELDS;
        set_cr_field(3'd0, cmp_kind(v, 0, 1));
      end
    end
    if (tk) begin
      if (w[0]) lr_q = pc_q;
      pc_q = tgt;
    end
    r.next_pc = pc_q;
    r.dest_index = wr ? idx : 5'd0;
    r.dest_value = wr ? v : 32'd0;
    r.dest_written = wr;
    r.cond_value = cr_q;
    r.branch_taken = tk;
    r.divide_by_zero = dz;
    return r;
  endfunction

  function automatic void queue_instr(input logic [4:0] cmd, input logic [31:0] w);
    ibeu_pkg::in_item_t it;
    it.command = cmd;
    it.instr_word = w;
    instr_queue.push_back(it);
  endfunction

  // random instruction, biased toward useful register and branch fields
  function automatic void queue_random_instr();
    logic [4:0] cmd;
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: cmd = 5'($urandom_range(0, 31));
      1, 2: cmd = 5'($urandom_range(ibeu_pkg::CMD_B, ibeu_pkg::CMD_BCCTR));
      3: cmd = 5'($urandom_range(ibeu_pkg::CMD_CMPI, ibeu_pkg::CMD_CMPL));
      default: cmd = 5'($urandom_range(0, 15));
    endcase
    if (cmd == ibeu_pkg::CMD_DIVW && $urandom_range(0, 3) != 0)
      w[20:0] = {w[20:16], 5'($urandom_range(1, 31)), w[10:0]};
    if (cmd == ibeu_pkg::CMD_BC && $urandom_range(0, 2) == 0) w[1] = 1'b0;
    queue_instr(cmd, w);
  endfunction

  // driver: instructions and configuration writes
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
      else if (cfg_req && !cfg_valid) begin
        cfg_valid <= 1'b1;
        cfg_index <= cfg_req_index;
        cfg_data <= cfg_req_data;
      end
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          result_queue.push_back(execute(in_data));
          instr_queue.pop_front();
        end
        if (instr_queue.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= instr_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare results and drive the receiver's ready
  always @(posedge clk) begin
    ibeu_pkg::out_item_t e;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = result_queue.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (hold_active) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (instr_queue.size() != 0 || in_valid || result_queue.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_req_index = index;
    cfg_req_data = data;
    cfg_req = 1'b1;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_req = 1'b0;
    case (index)
      ibeu_pkg::CFG_START: begin pc_q = data; end
      ibeu_pkg::CFG_SO:    so_q = data[0];
      ibeu_pkg::CFG_COUNT: ctr_q = data;
      default: ;
    endcase
  endtask

  task automatic run_random(input int n, input int unsigned idle, input int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) queue_random_instr();
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    cr_q = '0; ctr_q = '0; lr_q = '0; pc_q = '0; so_q = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation, special cases
    write_reg(ibeu_pkg::CFG_START, 32'hFFFFFFF8);
    write_reg(ibeu_pkg::CFG_SO, 32'd1);
    write_reg(ibeu_pkg::CFG_COUNT, 32'd2);
    // r1 = 0x80000000, rA zero
    queue_instr(ibeu_pkg::CMD_ADDIS, {6'd0, 5'd1, 5'd0, 16'h8000});
    queue_instr(ibeu_pkg::CMD_ADDI, {6'd0, 5'd2, 5'd0, 16'hFFFF});   // r2 = -1
    queue_instr(ibeu_pkg::CMD_ADDI, {6'd0, 5'd3, 5'd2, 16'h7FFF});
    // minimum over minus one, then divide by zero
    queue_instr(ibeu_pkg::CMD_DIVW, {6'd0, 5'd4, 5'd1, 5'd2, 11'd1});
    queue_instr(ibeu_pkg::CMD_DIVW, {6'd0, 5'd5, 5'd3, 5'd0, 11'd1});
    queue_instr(ibeu_pkg::CMD_DIVW, {6'd0, 5'd6, 5'd3, 5'd2, 11'd1});
    queue_instr(ibeu_pkg::CMD_ADD, {6'd0, 5'd7, 5'd1, 5'd2, 11'd1});
    queue_instr(ibeu_pkg::CMD_SUBF, {6'd0, 5'd8, 5'd1, 5'd3, 11'd1});
    queue_instr(ibeu_pkg::CMD_MULLI, {6'd0, 5'd9, 5'd3, 16'h8001});
    queue_instr(ibeu_pkg::CMD_MULLW, {6'd0, 5'd10, 5'd1, 5'd2, 11'd1});
    for (int c = ibeu_pkg::CMD_ORI; c <= ibeu_pkg::CMD_XOR; c++)
      queue_instr(c[4:0], {6'd0, 5'd2, 5'd11, 16'hF0F1});
    queue_instr(ibeu_pkg::CMD_CMPI, {6'd0, 3'd7, 2'd3, 5'd1, 16'h0000});
    queue_instr(ibeu_pkg::CMD_CMP, {6'd0, 3'd1, 2'd0, 5'd3, 5'd2, 11'd0});
    queue_instr(ibeu_pkg::CMD_CMPLI, {6'd0, 3'd2, 2'd0, 5'd1, 16'hFFFF});
    queue_instr(ibeu_pkg::CMD_CMPL, {6'd0, 3'd3, 2'd0, 5'd2, 5'd1, 11'd0});
    // backward with link, decrement not taken, old link target, count target
    queue_instr(ibeu_pkg::CMD_B, {6'd0, 24'h800000, 2'b01});
    queue_instr(ibeu_pkg::CMD_BC, {6'd0, 5'h00, 5'd31, 16'h0010});
    queue_instr(ibeu_pkg::CMD_BCLR, {6'd0, 5'h14, 5'd0, 16'h0001});
    queue_instr(ibeu_pkg::CMD_BCCTR, {6'd0, 5'h14, 5'd0, 16'h0000});
    queue_instr(5'd31, 32'hFFFFFFFF);
    wait_drained();

    // random phases under different configurations and pressure
    write_reg(ibeu_pkg::CFG_SO, 32'd0);
    write_reg(ibeu_pkg::CFG_COUNT, 32'd0);
    run_random(130, 0, 0);
    write_reg(ibeu_pkg::CFG_START, 32'd0);
    write_reg(ibeu_pkg::CFG_COUNT, 32'hFFFFFFFF);
    run_random(130, 54, 0);
    write_reg(ibeu_pkg::CFG_SO, 32'd1);
    write_reg(ibeu_pkg::CFG_COUNT, $urandom_range(0, 8));
    run_random(130, 0, 54);
    write_reg(ibeu_pkg::CFG_START, $urandom);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_active <= 1'b1;
        repeat (300) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
    repeat (40) queue_random_instr();
    wait_drained();
    run_random(130, 20, 20);
    write_reg(ibeu_pkg::CFG_SO, 32'd0);
    run_random(90, 0, 0);

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
